[rtl/rdm_pkg.sv]
// Package: shared constants, types and state codes of the RMS dBm level meter.
package rdm_pkg;

   // Block length limit and field widths
   localparam int MAX_BLOCK  = 1024;
   localparam int SAMPLE_W   = 16;
   localparam int LEVEL_W    = 16;

   // Square of a 16-bit sample is at most 2^30
   localparam int SQ_W       = 31;
   localparam int SUM_W      = SQ_W + $clog2(MAX_BLOCK);
   localparam int CNT_W      = $clog2(MAX_BLOCK + 1);

   // Block queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // log2 engine: 64-bit normaliser in binary steps, then Q30 squaring
   localparam int NORM_W     = 64;
   localparam int LZ_W       = $clog2(NORM_W);
   localparam int NORM_STEPS = LZ_W;
   localparam int MANT_FRAC  = 30;
   localparam int MANT_W     = MANT_FRAC + 1;
   localparam int FRAC_BITS  = 16;
   localparam int STEP_W     = $clog2(FRAC_BITS);
   localparam int LOG_W      = LZ_W + FRAC_BITS;
   localparam int DIFF_W     = LOG_W + 1;

   // Level scaling: 10*log10(2) in Q16, reference offset in Q32
   localparam int    SCALE_W         = 19;
   localparam int    TEN_LOG10_2_Q16 = 197283;
   localparam int    PROD_W          = DIFF_W + SCALE_W;
   localparam int    P_W             = PROD_W + 1;
   localparam longint OFFSET_Q32     = 64'sd361171027919;
   localparam int    LEVEL_SHIFT     = 24;
   localparam longint ROUND_HALF     = 64'sd1 << (LEVEL_SHIFT - 1);
   localparam int    R_W             = P_W - LEVEL_SHIFT;
   localparam int    LEVEL_MAX       = 32767;
   localparam int    LEVEL_MIN       = -32768;

   // One finished block as handed from front to back
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] cnt;
      logic             too_long;
   } rdm_entry_type;

   typedef struct packed {
      logic          valid;
      rdm_entry_type entry;
   } rdm_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } rdm_qstat_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_NORM,
      BK_FRAC,
      BK_MUL,
      BK_ROUND
   } rdm_back_state_type;

endpackage

[rtl/rdm_if.sv]
// Interfaces: sample request channel and level response channel.
interface rdm_req_if;
   import rdm_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface rdm_rsp_if;
   import rdm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [LEVEL_W-1:0] level_dbm_q8;
   logic                      silent;
   logic                      overflow;

   modport source (output valid, output level_dbm_q8, output silent, output overflow,
                   input ready);
   modport sink   (input valid, input level_dbm_q8, input silent, input overflow,
                   output ready);
endinterface

[rtl/rdm_front.sv]
// Front end: squares samples, accumulates block energy and count, queues finished blocks.
module rdm_front (
   input  logic                   clock,
   input  logic                   reset,
   rdm_req_if.sink                req_chan,
   input  rdm_pkg::rdm_qstat_type qstat,
   output rdm_pkg::rdm_push_type  push
);
   import rdm_pkg::*;

   logic                    sq_valid_ff, sq_valid_in;
   logic [SQ_W-1:0]         sq_ff, sq_in;
   logic                    sq_last_ff, sq_last_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    too_long_ff, too_long_in;

   logic signed [2*SAMPLE_W-1:0] square;
   logic                    req_fire;
   logic                    sq_fire;
   logic                    room;
   logic [SUM_W-1:0]        sum_next;
   logic [CNT_W-1:0]        cnt_next;
   logic                    too_long_next;

   // a last sample waits while the queue is full
   assign sq_fire        = sq_valid_ff && !(sq_last_ff && qstat.full);
   assign req_chan.ready = !sq_valid_ff || sq_fire;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign square         = req_chan.sample * req_chan.sample;

   assign room          = cnt_ff < CNT_W'(MAX_BLOCK);
   assign sum_next      = room ? sum_ff + SUM_W'(sq_ff) : sum_ff;
   assign cnt_next      = room ? cnt_ff + CNT_W'(1) : cnt_ff;
   assign too_long_next = too_long_ff | !room;

   assign push.valid          = sq_fire && sq_last_ff;
   assign push.entry.sum      = sum_next;
   assign push.entry.cnt      = cnt_next;
   assign push.entry.too_long = too_long_next;

   always_comb begin
      sq_valid_in = sq_valid_ff;
      sq_in       = sq_ff;
      sq_last_in  = sq_last_ff;
      if (req_fire) begin
         sq_valid_in = 1'b1;
         sq_in       = square[SQ_W-1:0];
         sq_last_in  = req_chan.last_sample;
      end else if (sq_fire) begin
         sq_valid_in = 1'b0;
      end
   end

   always_comb begin
      sum_in      = sum_ff;
      cnt_in      = cnt_ff;
      too_long_in = too_long_ff;
      if (sq_fire) begin
         if (sq_last_ff) begin
            sum_in      = '0;
            cnt_in      = '0;
            too_long_in = 1'b0;
         end else begin
            sum_in      = sum_next;
            cnt_in      = cnt_next;
            too_long_in = too_long_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         sum_ff      <= '0;
         cnt_ff      <= '0;
         too_long_ff <= 1'b0;
      end else begin
         sq_valid_ff <= sq_valid_in;
         sum_ff      <= sum_in;
         cnt_ff      <= cnt_in;
         too_long_ff <= too_long_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff      <= sq_in;
      sq_last_ff <= sq_last_in;
   end

endmodule

[rtl/rdm_queue.sv]
// Short block queue between the accumulating front and the log back end.
module rdm_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  rdm_pkg::rdm_push_type  push,
   input  logic                   pop,
   output rdm_pkg::rdm_entry_type head,
   output rdm_pkg::rdm_qstat_type qstat
);
   import rdm_pkg::*;

   rdm_entry_type     entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign qstat.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign qstat.empty = count_ff == '0;
   assign head        = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      case ({push.valid, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

[rtl/rdm_back.sv]
// Back end: iterative log2 of energy and count, dB scaling, rounding and response register.
module rdm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  rdm_pkg::rdm_entry_type head,
   input  rdm_pkg::rdm_qstat_type qstat,
   output logic                   pop,
   rdm_rsp_if.source              rsp_chan
);
   import rdm_pkg::*;

   rdm_back_state_type       state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     pass_ff, pass_in;
   logic                     silent_ff, silent_in;
   logic                     too_long_ff, too_long_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [NORM_W-1:0]        v_ff, v_in;
   logic [LZ_W-1:0]          lz_ff, lz_in;
   logic [MANT_W-1:0]        m_ff, m_in;
   logic [FRAC_BITS-1:0]     frac_ff, frac_in;
   logic [LOG_W-1:0]         lsum_ff, lsum_in;
   logic [LOG_W-1:0]         lcnt_ff, lcnt_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   logic                     rsp_silent_ff, rsp_silent_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   logic                     last_norm;
   logic                     last_frac;
   logic                     round_done;
   logic [LZ_W-1:0]          sh;
   logic                     hi_zero;
   logic [NORM_W-1:0]        v_norm;
   logic [2*MANT_W-1:0]      m_sq;
   logic [MANT_W:0]          m_t;
   logic [MANT_W-1:0]        m_next;
   logic [FRAC_BITS-1:0]     frac_next;
   logic [LZ_W-1:0]          top;
   logic [LOG_W-1:0]         log_val;
   logic signed [DIFF_W-1:0] diff;
   logic signed [SCALE_W-1:0] scale;
   logic signed [P_W-1:0]    p_val;
   logic signed [R_W-1:0]    r_val;
   logic signed [LEVEL_W-1:0] level_sat;

   assign last_norm = step_ff == STEP_W'(NORM_STEPS - 1);
   assign last_frac = step_ff == STEP_W'(FRAC_BITS - 1);

   // normaliser: halving shift each step, skip a zero top slice
   assign sh      = LZ_W'(NORM_W / 2) >> step_ff;
   assign hi_zero = (v_ff & ~({NORM_W{1'b1}} >> sh)) == '0;
   assign v_norm  = hi_zero ? (v_ff << sh) : v_ff;

   // fraction bit: square the Q30 mantissa, renormalise if it reached 2
   assign m_sq      = m_ff * m_ff;
   assign m_t       = m_sq[2*MANT_W-1:MANT_FRAC];
   assign m_next    = m_t[MANT_W] ? m_t[MANT_W:1] : m_t[MANT_W-1:0];
   assign frac_next = {frac_ff[FRAC_BITS-2:0], m_t[MANT_W]};
   assign top       = LZ_W'(NORM_W - 1) - lz_ff;
   assign log_val   = {top, frac_next};

   assign diff  = $signed({1'b0, lsum_ff}) - $signed({1'b0, lcnt_ff});
   assign scale = SCALE_W'(TEN_LOG10_2_Q16);

   // Q32 level less offset, rounded half up to Q8.8 by flooring shift
   assign p_val = P_W'(prod_ff) - P_W'(OFFSET_Q32) + P_W'(ROUND_HALF);
   assign r_val = p_val[P_W-1:LEVEL_SHIFT];

   always_comb begin
      if (r_val > R_W'(LEVEL_MAX)) begin
         level_sat = LEVEL_W'(LEVEL_MAX);
      end else if (r_val < R_W'(LEVEL_MIN)) begin
         level_sat = LEVEL_W'(LEVEL_MIN);
      end else begin
         level_sat = r_val[LEVEL_W-1:0];
      end
   end

   // control outputs
   always_comb begin
      pop        = (state_ff == BK_IDLE) && !qstat.empty;
      round_done = (state_ff == BK_ROUND) && (!rsp_valid_ff || rsp_chan.ready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!qstat.empty) begin
               state_in = (head.sum == '0) ? BK_ROUND : BK_NORM;
            end
         end
         BK_NORM: begin
            if (last_norm) begin
               state_in = BK_FRAC;
            end
         end
         BK_FRAC: begin
            if (last_frac) begin
               state_in = pass_ff ? BK_MUL : BK_NORM;
            end
         end
         BK_MUL: begin
            state_in = BK_ROUND;
         end
         BK_ROUND: begin
            if (round_done) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      step_in     = step_ff;
      pass_in     = pass_ff;
      silent_in   = silent_ff;
      too_long_in = too_long_ff;
      cnt_in      = cnt_ff;
      v_in        = v_ff;
      lz_in       = lz_ff;
      m_in        = m_ff;
      frac_in     = frac_ff;
      lsum_in     = lsum_ff;
      lcnt_in     = lcnt_ff;
      prod_in     = prod_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               step_in     = '0;
               pass_in     = 1'b0;
               silent_in   = head.sum == '0;
               too_long_in = head.too_long;
               cnt_in      = head.cnt;
               v_in        = NORM_W'(head.sum);
               lz_in       = '0;
            end
         end
         BK_NORM: begin
            if (hi_zero) begin
               v_in  = v_ff << sh;
               lz_in = lz_ff + sh;
            end
            frac_in = '0;
            if (last_norm) begin
               step_in = '0;
               m_in    = v_norm[NORM_W-1 -: MANT_W];
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         BK_FRAC: begin
            m_in    = m_next;
            frac_in = frac_next;
            if (last_frac) begin
               step_in = '0;
               if (pass_ff) begin
                  lcnt_in = log_val;
               end else begin
                  lsum_in = log_val;
                  pass_in = 1'b1;
                  v_in    = NORM_W'(cnt_ff);
                  lz_in   = '0;
               end
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         BK_MUL: begin
            prod_in = diff * scale;
         end
         default: begin
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      level_in      = level_ff;
      rsp_silent_in = rsp_silent_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      if (round_done) begin
         rsp_valid_in  = 1'b1;
         level_in      = silent_ff ? LEVEL_W'(LEVEL_MIN) : level_sat;
         rsp_silent_in = silent_ff;
         rsp_ovf_in    = too_long_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.level_dbm_q8 = level_ff;
   assign rsp_chan.silent       = rsp_silent_ff;
   assign rsp_chan.overflow     = rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      pass_ff       <= pass_in;
      silent_ff     <= silent_in;
      too_long_ff   <= too_long_in;
      cnt_ff        <= cnt_in;
      v_ff          <= v_in;
      lz_ff         <= lz_in;
      m_ff          <= m_in;
      frac_ff       <= frac_in;
      lsum_ff       <= lsum_in;
      lcnt_ff       <= lcnt_in;
      prod_ff       <= prod_in;
      level_ff      <= level_in;
      rsp_silent_ff <= rsp_silent_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

endmodule

[rtl/block_rms_dbm_meter.sv]
// Top level: block RMS level meter in dBm, front accumulator, block queue and log back end.
//
// Each request carries one signed 16-bit PCM sample and a last-of-block flag.
// The front takes one request per clock unless stalled: it squares the
// sample into a register, from which it adds it to the block energy and
// count. Samples beyond MAX_BLOCK in one block are dropped and mark the
// block as overflowed. On the last sample the block's energy, count and
// overflow mark go into a two-entry queue, and the front only stalls on a
// last sample while both queue slots hold blocks. The back end works one
// block at a time: a shared log2 unit takes a six-step binary normalise
// plus sixteen squaring steps (one 31x31 multiply a cycle), run once for
// the energy and once for the count, then a dB multiply state and a round
// and saturate state. A block whose energy is zero (silent: level -32768,
// no log taken) goes from the queue straight to round and saturate. The
// result is signed Q8.8 dBm, rounded half up and saturated to 16 bits. A
// response that is not taken holds in its output register while the back
// end goes on with the next queued block up to its round and saturate state.
module block_rms_dbm_meter (
   input  logic       clock,
   input  logic       reset,
   rdm_req_if.sink    req_chan,
   rdm_rsp_if.source  rsp_chan
);
   import rdm_pkg::*;

   rdm_push_type  push;
   rdm_qstat_type qstat;
   rdm_entry_type head;
   logic          pop;

   rdm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .qstat    (qstat),
      .push     (push)
   );

   rdm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .qstat (qstat)
   );

   rdm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .qstat    (qstat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   // front never pushes a finished block into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !qstat.full)
      else $error("block pushed into full queue");

   // back only takes a block that is there
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("block popped from empty queue");

   // a silent block always reports the floor level
   a_silent_floor: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.silent) |-> (rsp_chan.level_dbm_q8 == LEVEL_W'(LEVEL_MIN)))
      else $error("silent response with non-floor level");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("response valid right after reset");

endmodule

[test/tb_block_rms_dbm_meter.sv]
// Testbench for block_rms_dbm_meter: directed and random sample blocks checked against a level predictor.
module tb_block_rms_dbm_meter;
   import rdm_pkg::*;

   // One expected block level, as the response channel should carry it
   typedef struct {
      logic signed [LEVEL_W-1:0] level;
      logic                      silent;
      logic                      overflow;
   } level_report_type;

   logic clock;
   logic reset;

   rdm_req_if req_bus ();
   rdm_rsp_if rsp_bus ();

   block_rms_dbm_meter i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Predictor state: energy and count of the block being gathered
   longint unsigned blk_energy;
   int unsigned     blk_count;
   bit              blk_too_long;

   level_report_type pending_levels[$];
   int unsigned     fail_count;
   int unsigned     requests_sent;

   // While set, neither side idles
   bit              steady;

   // ---------------------------------------------------------------------
   // Clock and time limit
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Time limit: a run that has not finished by this delay is reported as failed
   initial begin
      #2000000;
      $display("block_rms_dbm_meter test failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Level predictor
   // ---------------------------------------------------------------------

   // log2 in Q16: top set bit as integer part, then 16 fraction bits from
   // repeated squaring of a Q30 mantissa, each bit truncated
   function automatic logic [LOG_W-1:0] log2_q16(input logic [63:0] x);
      int          top;
      int          i;
      logic [63:0] mant;
      logic [15:0] frac;
      frac = '0;
      if (x == 64'd0) begin
         return '0;
      end
      top = 63;
      while (top > 0 && !x[top]) top--;
      if (top >= MANT_FRAC) begin
         mant = x >> (top - MANT_FRAC);
      end else begin
         mant = x << (MANT_FRAC - top);
      end
      for (i = 0; i < FRAC_BITS; i++) begin
         mant = (mant * mant) >> MANT_FRAC;
         frac = {frac[14:0], 1'b0};
         if (mant >= (64'd2 << MANT_FRAC)) begin
            mant  = mant >> 1;
            frac[0] = 1'b1;
         end
      end
      return {top[LZ_W-1:0], frac};
   endfunction

   // Mean-square level against the dBm reference, Q8.8, half-up, saturated
   function automatic logic signed [LEVEL_W-1:0] level_q8(input longint unsigned energy,
                                                           input int unsigned count);
      longint lg_energy;
      longint lg_count;
      longint prod_q32;
      longint rounded;
      lg_energy = longint'(log2_q16(energy));
      lg_count  = longint'(log2_q16(64'(count)));
      prod_q32  = (lg_energy - lg_count) * longint'(TEN_LOG10_2_Q16) - OFFSET_Q32;
      rounded   = (prod_q32 + ROUND_HALF) >>> LEVEL_SHIFT;
      if (rounded > LEVEL_MAX) rounded = LEVEL_MAX;
      if (rounded < LEVEL_MIN) rounded = LEVEL_MIN;
      return rounded[LEVEL_W-1:0];
   endfunction

   // Fold one accepted request into the block; on the last sample queue
   // the expected level and start a fresh block
   task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] s, input bit last);
      level_report_type rep;
      longint        sv;
      sv = longint'(s);
      if (blk_count < MAX_BLOCK) begin
         blk_energy += longint'(sv * sv);
         blk_count++;
      end else begin
         // samples past the limit are dropped but flag the block
         blk_too_long = 1'b1;
      end
      if (last) begin
         rep.silent   = (blk_energy == 0);
         rep.level    = rep.silent ? LEVEL_W'(LEVEL_MIN) : level_q8(blk_energy, blk_count);
         rep.overflow = blk_too_long;
         pending_levels.push_back(rep);
         blk_energy   = 0;
         blk_count    = 0;
         blk_too_long = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------

   // Offer one sample request, with random gaps ahead of it unless steady;
   // returns once it has been taken
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit last);
      while (!steady && $urandom_range(99) < 14) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.sample      <= s;
      req_bus.last_sample <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      accumulate_sample(s, last);
      requests_sent++;
   endtask

   // ---------------------------------------------------------------------
   // Response side: random back-pressure and checking
   // ---------------------------------------------------------------------
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= steady || ($urandom_range(99) >= 14);
      end
   end

   // Outputs are sampled at the edge, before this edge's updates land
   always @(posedge clock) begin
      level_report_type exp_rep;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_levels.size() == 0) begin
            $error("unexpected response: level_dbm_q8 %0d silent %0b overflow %0b",
                   rsp_bus.level_dbm_q8, rsp_bus.silent, rsp_bus.overflow);
            fail_count++;
         end else begin
            exp_rep = pending_levels.pop_front();
            if (rsp_bus.level_dbm_q8 !== exp_rep.level) begin
               $error("level_dbm_q8: expected %0d, actual %0d",
                      exp_rep.level, rsp_bus.level_dbm_q8);
               fail_count++;
            end
            if (rsp_bus.silent !== exp_rep.silent) begin
               $error("silent: expected %0b, actual %0b", exp_rep.silent, rsp_bus.silent);
               fail_count++;
            end
            if (rsp_bus.overflow !== exp_rep.overflow) begin
               $error("overflow: expected %0b, actual %0b",
                      exp_rep.overflow, rsp_bus.overflow);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Single-sample blocks at the field extremes, silent single zero,
   // alternating bit patterns
   task automatic test_single_extremes();
      send_sample(16'sd0, 1'b1);
      send_sample(-16'sd32768, 1'b1);
      send_sample(16'sd32767, 1'b1);
      send_sample(16'sd1, 1'b1);
      send_sample(-16'sd1, 1'b1);
      send_sample(16'sh5555, 1'b1);
      send_sample(16'shAAAA, 1'b1);
   endtask

   // Short multi-sample blocks: all-zero (silent), zeros around one hit,
   // full-scale square wave, tiny signal
   task automatic test_short_blocks();
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b1);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd3, 1'b0);
      send_sample(16'sd0, 1'b1);
      send_sample(16'sd32767, 1'b0);
      send_sample(-16'sd32768, 1'b0);
      send_sample(16'sd32767, 1'b0);
      send_sample(-16'sd32768, 1'b1);
      send_sample(16'sd1, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b1);
   endtask

   // Block one sample over the limit: MAX_BLOCK small samples fill the
   // count, and the full-scale one after them must be dropped and flagged.
   // Run without idling on either side.
   task automatic test_long_block();
      int i;
      steady = 1'b1;
      for (i = 0; i <= MAX_BLOCK; i++) begin
         send_sample((i < MAX_BLOCK) ? 16'sd5 : -16'sd32768, i == MAX_BLOCK);
      end
      steady = 1'b0;
   endtask

   // Random blocks: mostly short, some single-sample blocks to
   // fill the block queue, a few longer; sample flavour chosen per block
   task automatic test_random_blocks();
      int unsigned start_count;
      int unsigned blk_len;
      int unsigned flavour;
      int unsigned pick;
      int          i;
      logic signed [SAMPLE_W-1:0] s;
      start_count = requests_sent;
      while (requests_sent - start_count < 200) begin
         // a stretch with no idling partway through
         steady = (requests_sent - start_count >= 60) && (requests_sent - start_count < 140);
         pick = $urandom_range(99);
         if (pick < 55)      blk_len = $urandom_range(8, 1);
         else if (pick < 80) blk_len = $urandom_range(40, 9);
         else if (pick < 95) blk_len = 1;
         else                blk_len = $urandom_range(80, 41);
         flavour = $urandom_range(4);
         for (i = 0; i < blk_len; i++) begin
            case (flavour)
               0: s = 16'($urandom);
               1: s = 16'($signed($urandom_range(6)) - 3);
               2: s = 16'sd0;
               3: begin
                  pick = $urandom_range(2);
                  s = (pick == 0) ? -16'sd32768 : (pick == 1) ? 16'sd32767 : 16'sd0;
               end
               default: s = ($urandom_range(3) == 0) ? 16'($urandom) : 16'sd0;
            endcase
            send_sample(s, i == blk_len - 1);
         end
      end
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      blk_energy    = 0;
      blk_count     = 0;
      blk_too_long  = 1'b0;
      fail_count    = 0;
      requests_sent = 0;
      steady        = 1'b0;

      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.sample      <= '0;
      req_bus.last_sample <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_extremes();
      test_short_blocks();
      test_long_block();
      test_random_blocks();

      req_bus.valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      // let any stray response show up
      repeat (100) @(posedge clock);

      if (fail_count == 0) begin
         $display("block_rms_dbm_meter test passed");
      end else begin
         $display("block_rms_dbm_meter test failed");
      end
      $finish;
   end

endmodule
